>>> hdl/assert_macros.svh
// Assertion macros shared by the decoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the clock and disabled while reset is low.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the clock and disabled while reset is low.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/tgarle_pkg.sv
// Shared types and constants for the true-color RLE line decoder.
`timescale 1ns / 1ps

package tgarle_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int LW_W       = 13;
    localparam int DEF_MAX_WIDTH = 4096;

    localparam logic [CFG_IDX_W-1:0] REG_RLE_ENABLED = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_DEPTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIRROR      = 3'd3;

    localparam logic [1:0] DEPTH_16 = 2'd0;
    localparam logic [1:0] DEPTH_24 = 2'd1;
    localparam logic [1:0] DEPTH_32 = 2'd2;

    localparam logic [LW_W-1:0] RST_LINE_WIDTH = 13'd640;
    localparam logic [LW_W-1:0] MIN_LINE_WIDTH = 13'd4;

    typedef struct packed {
        logic            rle_enabled;
        logic [1:0]      pixel_depth;
        logic [LW_W-1:0] line_width;
        logic            mirror;
    } t_cfg;

    typedef struct packed {
        logic take;
        logic step;
        logic restart;
    } t_cmd;

    typedef struct packed {
        logic emits;
        logic more;
    } t_stat;

endpackage

>>> hdl/tga_truecolor_rle_line_decoder.sv
// Top level of the true-color RLE scanline decoder.
//
//   Channel  Direction  Handshake                  Payload
//   in       input      i_in_valid / o_in_ready    i_data_byte
//   out      output     o_out_valid / i_out_ready  color, column, count, line_done
//   cfg      input      i_cfg_we                   i_cfg_index, i_cfg_data
//
// One byte is taken per cycle while no run span is pending and the result register is free or being emptied.
// A completed pixel shows its first span on the outputs in the cycle after its last byte.
// A run that crosses a line end holds off the input until its further spans are issued,
// as the single span unit clips each piece against the line end.
// Reset and any write to one of the four defined register indices clear the packet, pixel and column state.
// A stalled result holds off every input byte, headers and partial pixel bytes included.
`timescale 1ns / 1ps

module tga_truecolor_rle_line_decoder
    import tgarle_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_data_byte,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [7:0]            o_red,
    output logic [7:0]            o_green,
    output logic [7:0]            o_blue,
    output logic [11:0]           o_first_column,
    output logic [7:0]            o_repeat_count,
    output logic                  o_line_done,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg  cfg;
    t_cmd  cmd;
    t_stat stat;
    logic  restart;

    tgarle_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_restart   (restart)
    );

    tgarle_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_restart   (restart),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    tgarle_dpath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_cmd          (cmd),
        .i_data_byte    (i_data_byte),
        .o_stat         (stat),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_first_column (o_first_column),
        .o_repeat_count (o_repeat_count),
        .o_line_done    (o_line_done)
    );

endmodule

>>> hdl/tgarle_regs.sv
// Configuration register file with restart strobe.
`timescale 1ns / 1ps

module tgarle_regs
    import tgarle_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg,
    output logic                  o_restart
);

    t_cfg r_cfg;

    assign o_restart = i_cfg_we && (i_cfg_index inside {REG_RLE_ENABLED, REG_PIXEL_DEPTH,
                                                        REG_LINE_WIDTH, REG_MIRROR});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rle_enabled <= 1'b0;
            r_cfg.pixel_depth <= DEPTH_24;
            r_cfg.line_width  <= RST_LINE_WIDTH;
            r_cfg.mirror      <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_RLE_ENABLED: begin
                    r_cfg.rle_enabled <= i_cfg_data[0];
                end
                REG_PIXEL_DEPTH: begin
                    r_cfg.pixel_depth <= i_cfg_data[1:0];
                end
                REG_LINE_WIDTH: begin
                    r_cfg.line_width <= i_cfg_data[LW_W-1:0];
                end
                REG_MIRROR: begin
                    r_cfg.mirror <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> hdl/tgarle_dpath.sv
// Datapath: packet state, pixel assembly, span calculation and result register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tgarle_dpath
    import tgarle_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_cmd        i_cmd,
    input  logic [7:0]  i_data_byte,
    output t_stat       o_stat,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [11:0] o_first_column,
    output logic [7:0]  o_repeat_count,
    output logic        o_line_done
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int EW   = CW + 1;
    localparam int SUMW = (EW > 9) ? EW : 9;

    logic          r_is_run;
    logic [7:0]    r_left;
    logic [1:0]    r_byte_idx;
    logic [23:0]   r_pix;
    logic [CW-1:0] r_col;
    logic [7:0]    r_rem;

    logic [EW-1:0]   w_eff;
    logic            hdr;
    logic [1:0]      last_idx;
    logic            complete;
    logic [23:0]     pix_merged;
    logic [7:0]      red_d;
    logic [7:0]      green_d;
    logic [7:0]      blue_d;
    logic [7:0]      span_len;
    logic [SUMW-1:0] l_ext;
    logic [SUMW-1:0] room;
    logic            span_done;
    logic [7:0]      cnt;
    logic [CW-1:0]   col_next;
    logic [7:0]      rem_next;
    logic [EW-1:0]   stored_full;

    always_comb begin
        if (i_cfg.line_width < MIN_LINE_WIDTH) begin
            w_eff = EW'(MIN_LINE_WIDTH);
        end else if (32'(i_cfg.line_width) > 32'(MAX_WIDTH)) begin
            w_eff = EW'(MAX_WIDTH);
        end else begin
            w_eff = EW'(i_cfg.line_width);
        end
    end

    assign hdr = i_cfg.rle_enabled && (r_left == 8'd0);

    always_comb begin
        case (i_cfg.pixel_depth)
            DEPTH_16: begin
                last_idx = 2'd1;
            end
            DEPTH_24: begin
                last_idx = 2'd2;
            end
            default: begin
                last_idx = 2'd3;
            end
        endcase
    end

    assign complete = (r_byte_idx >= last_idx);

    always_comb begin
        case (r_byte_idx)
            2'd0: begin
                pix_merged = {r_pix[23:8], i_data_byte};
            end
            2'd1: begin
                pix_merged = {r_pix[23:16], i_data_byte, r_pix[7:0]};
            end
            2'd2: begin
                pix_merged = {i_data_byte, r_pix[15:0]};
            end
            default: begin
                pix_merged = r_pix;
            end
        endcase
    end

    always_comb begin
        if (i_cfg.pixel_depth == DEPTH_16) begin
            blue_d  = {pix_merged[4:0], 3'b000};
            green_d = {pix_merged[9:5], 3'b000};
            red_d   = {pix_merged[14:10], 3'b000};
        end else begin
            blue_d  = pix_merged[7:0];
            green_d = pix_merged[15:8];
            red_d   = pix_merged[23:16];
        end
    end

    // A span covers the remaining pixels of a run, or else a single pixel, clipped at the end of the line.
    always_comb begin
        if (i_cmd.step) begin
            span_len = r_rem;
        end else if (i_cfg.rle_enabled && r_is_run) begin
            span_len = r_left;
        end else begin
            span_len = 8'd1;
        end
        l_ext     = SUMW'(span_len);
        room      = SUMW'(w_eff) - SUMW'(r_col);
        span_done = (l_ext >= room);
        cnt       = span_done ? 8'(room) : span_len;
        col_next  = span_done ? '0 : CW'(SUMW'(r_col) + l_ext);
        rem_next  = 8'(l_ext - room);
        if (i_cfg.mirror) begin
            stored_full = w_eff - EW'(1) - EW'(r_col);
        end else begin
            stored_full = EW'(r_col);
        end
    end

    assign o_stat.emits = !hdr && complete;
    assign o_stat.more  = (l_ext > room);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.restart) begin
            r_is_run   <= 1'b0;
            r_left     <= 8'd0;
            r_byte_idx <= 2'd0;
            r_pix      <= 24'd0;
            r_col      <= '0;
        end else if (i_cmd.take) begin
            if (hdr) begin
                r_is_run   <= i_data_byte[7];
                r_left     <= {1'b0, i_data_byte[6:0]} + 8'd1;
                r_byte_idx <= 2'd0;
            end else if (complete) begin
                r_byte_idx <= 2'd0;
                r_col      <= col_next;
                r_rem      <= rem_next;
                if (i_cfg.rle_enabled) begin
                    if (r_is_run) begin
                        r_left <= 8'd0;
                    end else begin
                        r_left <= r_left - 8'd1;
                    end
                end
            end else begin
                r_byte_idx <= r_byte_idx + 2'd1;
                r_pix      <= pix_merged;
            end
        end else if (i_cmd.step) begin
            r_col <= col_next;
            r_rem <= rem_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && !hdr && complete) begin
            o_red          <= red_d;
            o_green        <= green_d;
            o_blue         <= blue_d;
            o_first_column <= 12'(stored_full);
            o_repeat_count <= cnt;
            o_line_done    <= span_done;
        end else if (i_cmd.step) begin
            o_first_column <= 12'(stored_full);
            o_repeat_count <= cnt;
            o_line_done    <= span_done;
        end
    end

    `ASSERT_IMPL(a_col_in_line, 1'b1, EW'(r_col) < w_eff, "Column left the line.")
    `ASSERT_IMPL(a_step_has_rem, i_cmd.step, r_rem != 8'd0, "Run step with no pixels left.")

endmodule

>>> hdl/tgarle_ctrl.sv
// Controller: input and output handshakes and run continuation sequencing.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tgarle_ctrl
    import tgarle_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_restart,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic {
        S_BYTE,
        S_RUN
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   slot_free;

    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_BYTE) && slot_free && !i_restart;
    assign o_out_valid = r_out_valid;

    assign o_cmd.take    = i_in_valid && o_in_ready;
    assign o_cmd.step    = (r_state == S_RUN) && slot_free;
    assign o_cmd.restart = i_restart;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_state     <= S_BYTE;
            r_out_valid <= 1'b0;
        end else if (o_cmd.take && i_stat.emits) begin
            r_out_valid <= 1'b1;
            if (i_stat.more) begin
                r_state <= S_RUN;
            end
        end else if (o_cmd.step) begin
            r_out_valid <= 1'b1;
            if (!i_stat.more) begin
                r_state <= S_BYTE;
            end
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    `ASSERT_IMPL(a_run_blocks_input, r_state == S_RUN, !o_in_ready, "Input taken during a run.")
    `ASSERT_NEXT(a_emit_loads, o_cmd.take && i_stat.emits && !i_restart, r_out_valid,
        "Completed pixel gave no result.")
    `ASSERT_NEXT(a_step_loads, o_cmd.step && !i_restart, r_out_valid,
        "Run step gave no result.")

endmodule
